/* sv/bph_pkg.sv */
// ----------------------------------------------------------------------------
// bph_pkg
// Types, constants and helpers shared by the byte pair histogram modules.
// ----------------------------------------------------------------------------
package bph_pkg;

    localparam int ALPHABET_SIZE = 256;
    localparam int COUNT_BITS    = 32;
    localparam int BYTE_W        = 8;
    localparam int OUT_W         = 32;
    localparam int PAIR_DEPTH    = ALPHABET_SIZE * ALPHABET_SIZE;
    localparam int ADDR_W        = $clog2(PAIR_DEPTH);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0]        op;
        logic [BYTE_W-1:0] byte_value;
        logic [BYTE_W-1:0] first_byte;
        logic [BYTE_W-1:0] second_byte;
    } item_t;

    typedef struct packed {
        logic [OUT_W-1:0] pair_count;
        logic [OUT_W-1:0] max_count;
        logic             have_previous;
    } result_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch_item;
        logic finish;
        logic sweep_write;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic sweep_last;
        logic is_clear;
    } dp_status_t;

    function automatic logic in_alphabet(input logic [BYTE_W-1:0] b);
        return ({1'b0, b} < (BYTE_W+1)'(ALPHABET_SIZE));
    endfunction

    function automatic logic [ADDR_W-1:0] pair_index(input logic [BYTE_W-1:0] f,
                                                     input logic [BYTE_W-1:0] s);
        logic [2*BYTE_W:0] full;
        full = (2*BYTE_W+1)'(f) * (2*BYTE_W+1)'(ALPHABET_SIZE) + (2*BYTE_W+1)'(s);
        return full[ADDR_W-1:0];
    endfunction

endpackage

/* sv/bph_ram.sv */
// ----------------------------------------------------------------------------
// bph_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module bph_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* sv/bph_ctrl.sv */
// ----------------------------------------------------------------------------
// bph_ctrl
// Sequencer: clearing sweep, item accept, counter read and result issue.
// ----------------------------------------------------------------------------
module bph_ctrl
    import bph_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_stall,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    localparam logic [1:0] S_CLEAR  = 2'd0;
    localparam logic [1:0] S_IDLE   = 2'd1;
    localparam logic [1:0] S_READ   = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.sweep_write = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.latch_item = 1'b1;
                    state_next     = S_READ;
                end
            end
            S_READ:
            begin
                // The RAM registers the counter addressed by the item here; the data arrives in S_FINISH.
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = status.is_clear ? S_CLEAR : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign item_stall = (state_reg != S_IDLE);

endmodule

/* sv/bph_datapath.sv */
// ----------------------------------------------------------------------------
// bph_datapath
// Counter store, previous byte, running maximum and the result register.
// ----------------------------------------------------------------------------
module bph_datapath
    import bph_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  item_t      item,
    input  dp_cmd_t    cmd,
    output dp_status_t status,
    output logic       result_valid,
    input  logic       result_stall,
    output result_t    result
);

    item_t             item_reg;
    logic [ADDR_W-1:0] index_reg;
    logic [ADDR_W-1:0] index_next;
    logic [BYTE_W-1:0] prev_byte_reg;
    logic              prev_valid_reg;
    logic [COUNT_BITS-1:0] max_reg;
    logic [COUNT_BITS-1:0] max_next;
    logic [ADDR_W-1:0] sweep_cnt_reg;
    result_t           result_reg;
    result_t           result_next;
    logic              result_valid_reg;

    logic [COUNT_BITS-1:0] rdata;
    logic [COUNT_BITS-1:0] bumped;
    logic                  byte_ok;
    logic                  do_count;
    logic                  read_ok;
    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [COUNT_BITS-1:0] ram_wdata;

    // An add addresses the pair it closes, a read the pair it asks for.
    always_comb
    begin
        if (item.op == OP_ADD)
        begin
            index_next = pair_index(prev_byte_reg, item.byte_value);
        end
        else
        begin
            index_next = pair_index(item.first_byte, item.second_byte);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_item)
        begin
            item_reg  <= item;
            index_reg <= index_next;
        end
        if (cmd.finish)
        begin
            result_reg <= result_next;
        end
    end

    assign byte_ok  = in_alphabet(item_reg.byte_value);
    assign do_count = (item_reg.op == OP_ADD) && byte_ok && prev_valid_reg;
    assign read_ok  = in_alphabet(item_reg.first_byte) && in_alphabet(item_reg.second_byte);
    assign bumped   = (rdata == COUNT_MAX) ? rdata : rdata + 1'b1;

    always_comb
    begin
        max_next = max_reg;
        if (do_count && (bumped > max_reg))
        begin
            max_next = bumped;
        end
    end

    always_comb
    begin
        result_next               = '0;
        result_next.max_count     = OUT_W'(max_next);
        result_next.have_previous = prev_valid_reg
                                    || ((item_reg.op == OP_ADD) && byte_ok);
        case (item_reg.op)
            OP_READ:
            begin
                if (read_ok)
                begin
                    result_next.pair_count = OUT_W'(rdata);
                end
            end
            OP_CLEAR:
            begin
                result_next.max_count     = '0;
                result_next.have_previous = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_byte_reg    <= '0;
            prev_valid_reg   <= 1'b0;
            max_reg          <= '0;
            sweep_cnt_reg    <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.sweep_write)
            begin
                sweep_cnt_reg <= status.sweep_last ? '0 : sweep_cnt_reg + 1'b1;
            end
            if (cmd.finish)
            begin
                result_valid_reg <= 1'b1;
                if (item_reg.op == OP_CLEAR)
                begin
                    prev_byte_reg  <= '0;
                    prev_valid_reg <= 1'b0;
                    max_reg        <= '0;
                end
                else if ((item_reg.op == OP_ADD) && byte_ok)
                begin
                    prev_byte_reg  <= item_reg.byte_value;
                    prev_valid_reg <= 1'b1;
                    max_reg        <= max_next;
                end
            end
            else if (result_valid_reg && !result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    assign ram_we    = cmd.sweep_write || (cmd.finish && do_count);
    assign ram_waddr = cmd.sweep_write ? sweep_cnt_reg : index_reg;
    assign ram_wdata = cmd.sweep_write ? '0 : bumped;

    bph_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (PAIR_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (index_reg),
        .rdata (rdata)
    );

    assign status.out_free   = !result_valid_reg || !result_stall;
    assign status.sweep_last = (sweep_cnt_reg == ADDR_W'(PAIR_DEPTH - 1));
    assign status.is_clear   = (item_reg.op == OP_CLEAR);

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

/* sv/byte_pair_histogram_top.sv */
// ----------------------------------------------------------------------------
// byte_pair_histogram_top
// Counts ordered pairs of consecutive stream bytes in a 2-D counter store.
// ----------------------------------------------------------------------------
// Usage:
// Items arrive on the item channel (item_valid, item_stall, item). An add
// carries one stream byte; a read asks for the counter of one byte pair; a
// clear zeroes every counter, the running maximum and the previous byte.
// Every item yields exactly one transfer on the result channel (result_valid,
// result_stall, result) holding the pair counter (reads only), the largest
// counter so far and whether a previous byte is held.
// Each item is accepted, then its counter comes through the registered RAM
// read, then the read-modify-write and result load follow. The single
// registered RAM read port is why the read has a step of its own.
// After reset, and after each clear, the block walks the whole counter RAM
// writing zeros, one entry per cycle (ALPHABET_SIZE squared entries, 65536 at
// the default size), and holds item_stall high meanwhile.
// The result register lets the next item be accepted while a result still
// waits; an item reaching its final step stalls there until the result
// register is free.
// ----------------------------------------------------------------------------
module byte_pair_histogram_top
    import bph_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    dp_cmd_t    cmd;
    dp_status_t status;

    bph_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .status     (status),
        .cmd        (cmd)
    );

    bph_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

/* sv/bph_checker.sv */
// ----------------------------------------------------------------------------
// bph_checker
// Port-level checks for the byte pair histogram, bound to the top level.
// ----------------------------------------------------------------------------
module bph_checker
    import bph_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    item_valid,
    input logic    item_stall,
    input item_t   item,
    input logic    result_valid,
    input logic    result_stall,
    input result_t result
);

    // A stalled result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(result))
        else $error("result changed while stalled");

    // No counter can exceed the running maximum.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.pair_count <= result.max_count)
        else $error("pair counter above running maximum");

    // A count only exists once some byte has been held.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.have_previous |-> result.max_count == '0)
        else $error("nonzero maximum without a previous byte");

    // The block is busy right after taking a clear item.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && (item.op == OP_CLEAR) |=> item_stall)
        else $error("item accepted right after a clear transfer");

endmodule

bind byte_pair_histogram_top bph_checker u_bph_checker (.*);
